/* src/assert_macros.svh */
// Assertion macros shared by the palette mapper RTL.
// Uses the clk and rst_n signals of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NPCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define NPCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/npcm_pkg.sv */
// Shared types and constants of the nearest palette color mapper.
// No dependencies.
`default_nettype none

package npcm_pkg;

  localparam int COLOR_W   = 8;
  localparam int OUT_IDX_W = 8;
  localparam int DIST_W    = 18;
  localparam int CFG_W     = 9;
  localparam int SQ_W      = 2 * COLOR_W;
  localparam int ENTRY_W   = 3 * COLOR_W;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // 3 * 256 * 256: starting best distance, also the empty-palette answer
  localparam logic [DIST_W-1:0] EMPTY_DIST  = 18'd196608;
  localparam logic [CFG_W-1:0]  COUNT_RESET = 9'd256;

  // controller -> datapath
  typedef struct packed {
    logic wr;        // store palette entry
    logic start;     // latch pixel, clear best, reset address
    logic rd;        // read next entry
    logic load_out;  // copy best into output register
  } npcm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_rd;
    logic pipe_busy;
    logic count_zero;
  } npcm_sts_t;

endpackage

`default_nettype wire

/* src/npcm_if.sv */
// Valid/ready channel interfaces: pixel/write input, result output, count config.
// Depends on npcm_pkg.
`default_nettype none

interface npcm_in_if import npcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         entry_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, command, entry_index, red, green, blue, input ready);
  modport sink   (input valid, command, entry_index, red, green, blue, output ready);
endinterface

interface npcm_out_if import npcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] color_index;
  logic [DIST_W-1:0]    best_distance;

  modport source (output valid, color_index, best_distance, input ready);
  modport sink   (input valid, color_index, best_distance, output ready);
endinterface

interface npcm_cfg_if import npcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] color_count;

  modport source (output valid, color_count, input ready);
  modport sink   (input valid, color_count, output ready);
endinterface

`default_nettype wire

/* src/nearest_palette_color_mapper_unit.sv */
// Top level of the nearest palette color mapper: controller plus datapath.
// Depends on npcm_pkg, npcm_if, npcm_ctrl, npcm_dp (and npcm_ram below it).
`default_nettype none

// Keeps a palette of PALETTE_DEPTH RGB entries in a single-port RAM and maps
// pixels to the nearest entry by squared Euclidean distance. A write item
// (command 0) stores {red, green, blue} at entry_index and gives no result;
// entry_index at or above PALETTE_DEPTH is dropped. A pixel item (command 1)
// scans entries 0 .. N-1, N = color_count saturated at PALETTE_DEPTH, and
// returns color_index and best_distance; only a strictly smaller distance
// replaces the best, so the lowest index wins a tie. With N = 0 the result is
// index 0, distance 196608. The RAM port reads one entry per cycle; a pixel
// goes through N reads, then the square and compare stages drain, then the
// best is copied into the result register. One item is in work at a time;
// the next item is taken in the cycle after the result register is loaded,
// even while that result still waits on out_ch. A pixel that finishes while
// the previous result still waits holds its result, and the input, until
// out_ch takes the older one. color_count resets to 256 and is written
// through cfg_ch, which is always ready; write it only while the block is
// idle. Palette contents are undefined after reset and must be written
// before they are searched.
module nearest_palette_color_mapper_unit import npcm_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input wire logic   clk,
  input wire logic   rst_n,
  npcm_in_if.sink    in_ch,
  npcm_out_if.source out_ch,
  npcm_cfg_if.sink   cfg_ch
);

  npcm_cmd_t cmd;
  npcm_sts_t sts;

  // config is a plain register write
  assign cfg_ch.ready = 1'b1;

  npcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  npcm_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_ch.valid),
    .cfg_count     (cfg_ch.color_count),
    .entry_index   (in_ch.entry_index),
    .red           (in_ch.red),
    .green         (in_ch.green),
    .blue          (in_ch.blue),
    .color_index   (out_ch.color_index),
    .best_distance (out_ch.best_distance)
  );

endmodule

`default_nettype wire

/* src/npcm_ram.sv */
// Generic single-port RAM, registered read (read-first).
// No dependencies.
`default_nettype none

module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* src/npcm_ctrl.sv */
// Controller of the palette mapper: idle / search / drain sequencing and result valid.
// Depends on npcm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module npcm_ctrl import npcm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_command,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire npcm_sts_t sts,
  output npcm_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.wr       = accept && (in_command == CMD_WRITE);
    cmd.start    = accept && (in_command == CMD_PIXEL);
    cmd.rd       = (state_r == ST_SEARCH);
    cmd.load_out = (state_r == ST_DRAIN) && !sts.pipe_busy && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = sts.count_zero ? ST_DRAIN : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd.load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pipeline must be empty whenever new work can come in
  `NPCM_ASSERT_IMP(a_idle_pipe_empty, in_ready, !sts.pipe_busy)
  // never overwrite a result that is still waiting
  `NPCM_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_r || out_ready)
  `NPCM_ASSERT_NXT(a_load_valid, cmd.load_out, out_valid_r)

endmodule

`default_nettype wire

/* src/npcm_dp.sv */
// Datapath of the palette mapper: count register, palette RAM, distance pipeline,
// running minimum and result register. Depends on npcm_pkg, npcm_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module npcm_dp import npcm_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire npcm_cmd_t            cmd,
  output npcm_sts_t                 sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_count,
  input  wire logic [7:0]           entry_index,
  input  wire logic [COLOR_W-1:0]   red,
  input  wire logic [COLOR_W-1:0]   green,
  input  wire logic [COLOR_W-1:0]   blue,
  output logic      [OUT_IDX_W-1:0] color_index,
  output logic      [DIST_W-1:0]    best_distance
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  logic [CFG_W-1:0]   color_count_r;
  logic [CNT_W-1:0]   limit_r, limit_nxt;
  logic [IDX_W-1:0]   addr_r;
  logic [COLOR_W-1:0] pix_red_r, pix_grn_r, pix_blu_r;
  logic               v1_r, v2_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r;
  logic [SQ_W-1:0]    sq_red_r, sq_grn_r, sq_blu_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [IDX_W-1:0]   out_idx_r;

  logic               wr_ok;
  logic [IDX_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [COLOR_W-1:0] d_red, d_grn, d_blu;
  logic [DIST_W-1:0]  dist_sum;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // count above depth saturates
  assign limit_nxt = (color_count_r > CFG_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                             : CNT_W'(color_count_r);

  // out-of-range writes are dropped
  assign wr_ok    = cmd.wr && ({1'b0, entry_index} < CFG_W'(PALETTE_DEPTH));
  assign ram_addr = cmd.wr ? entry_index[IDX_W-1:0] : addr_r;

  npcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_ok),
    .addr  (ram_addr),
    .wdata ({red, green, blue}),
    .rdata (ram_rdata)
  );

  assign d_red = abs_diff(ram_rdata[3*COLOR_W-1:2*COLOR_W], pix_red_r);
  assign d_grn = abs_diff(ram_rdata[2*COLOR_W-1:COLOR_W],   pix_grn_r);
  assign d_blu = abs_diff(ram_rdata[COLOR_W-1:0],           pix_blu_r);

  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_grn_r) + DIST_W'(sq_blu_r);

  assign sts.last_rd    = cmd.rd && ((CNT_W'(addr_r) + CNT_W'(1)) == limit_r);
  assign sts.pipe_busy  = v1_r || v2_r;
  assign sts.count_zero = (color_count_r == '0);

  assign color_index   = OUT_IDX_W'(out_idx_r);
  assign best_distance = out_dist_r;

  // config and pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= COUNT_RESET;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_count_r <= cfg_count;
      end
      v1_r <= cmd.rd;
      v2_r <= v1_r;
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_red_r <= red;
      pix_grn_r <= green;
      pix_blu_r <= blue;
      limit_r   <= limit_nxt;
      addr_r    <= '0;
    end else if (cmd.rd) begin
      addr_r <= addr_r + IDX_W'(1);
    end
    idx1_r   <= addr_r;
    idx2_r   <= idx1_r;
    sq_red_r <= {{COLOR_W{1'b0}}, d_red} * {{COLOR_W{1'b0}}, d_red};
    sq_grn_r <= {{COLOR_W{1'b0}}, d_grn} * {{COLOR_W{1'b0}}, d_grn};
    sq_blu_r <= {{COLOR_W{1'b0}}, d_blu} * {{COLOR_W{1'b0}}, d_blu};
    // strict compare: lowest index keeps a tie
    if (cmd.start) begin
      best_dist_r <= EMPTY_DIST;
      best_idx_r  <= '0;
    end else if (v2_r && (dist_sum < best_dist_r)) begin
      best_dist_r <= dist_sum;
      best_idx_r  <= idx2_r;
    end
    if (cmd.load_out) begin
      out_dist_r <= best_dist_r;
      out_idx_r  <= best_idx_r;
    end
  end

  `NPCM_ASSERT_IMP(a_rd_in_range, v1_r, CNT_W'(idx1_r) < limit_r)
  `NPCM_ASSERT_NXT(a_start_clears, cmd.start, best_dist_r == EMPTY_DIST)
  `NPCM_ASSERT_IMP(a_no_wr_busy, cmd.wr, !cmd.rd && !v1_r && !v2_r)

endmodule

`default_nettype wire
